// File: hdl/qsgpc_pkg.sv
// Package for the quadruped servo gait and pose controller.
// Holds joint indexes, command codes, gait constants and the angle-to-duty function.
// No dependencies.
package qsgpc_pkg;

  localparam int unsigned NumJoints = 4;
  localparam int unsigned AngleW    = 10;
  localparam int unsigned OffsetW   = 9;
  localparam int unsigned DutyW     = 11;
  localparam int unsigned PhaseW    = 8;

  localparam int unsigned DutyMin   = 204;
  localparam int unsigned DutyMax   = 1024;
  localparam int unsigned AngleMax  = 180;
  localparam int unsigned AngleMid  = 90;
  localparam int unsigned PhaseStep = 5;

  // floor((DutyMax - DutyMin) * a / AngleMax) == (a * DutyRecip) >> DutyShift for a in 0..180
  localparam int unsigned DutyShift = 16;
  localparam int unsigned DutyRecip = 298562;
  localparam int unsigned RecipW    = 19;

  localparam logic [1:0] JBackLeft   = 2'd0;
  localparam logic [1:0] JFrontRight = 2'd1;
  localparam logic [1:0] JFrontLeft  = 2'd2;
  localparam logic [1:0] JBackRight  = 2'd3;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_TARGET = 2'd1,
    ACT_POSE   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    GAIT_NONE = 2'd0,
    GAIT_FWD  = 2'd1,
    GAIT_BWD  = 2'd2
  } gait_e;

  typedef enum logic [2:0] {
    GRP_BACK_LEFT   = 3'd0,
    GRP_FRONT_RIGHT = 3'd1,
    GRP_FRONT_LEFT  = 3'd2,
    GRP_BACK_RIGHT  = 3'd3,
    GRP_ALL         = 3'd4,
    GRP_FRONT       = 3'd5,
    GRP_BACK        = 3'd6,
    GRP_NONE        = 3'd7
  } group_e;

  typedef enum logic [2:0] {
    POSE_FORWARD      = 3'd0,
    POSE_BACKWARD     = 3'd1,
    POSE_SIT          = 3'd2,
    POSE_STAND        = 3'd3,
    POSE_STRETCH_DOWN = 3'd4,
    POSE_STRETCH_BACK = 3'd5,
    POSE_STOP         = 3'd6,
    POSE_OTHER        = 3'd7
  } pose_e;

  typedef logic signed [AngleW-1:0]  angle_t;
  typedef logic signed [OffsetW-1:0] offset_t;
  typedef logic        [DutyW-1:0]   duty_t;
  typedef logic        [PhaseW-1:0]  phase_t;

  function automatic duty_t duty_of(angle_t ang, offset_t off);
    logic signed [AngleW:0]          sum;
    logic        [PhaseW-1:0]        clamped;
    logic        [PhaseW+RecipW-1:0] prod;
    sum = {ang[AngleW-1], ang} + {{(AngleW+1-OffsetW){off[OffsetW-1]}}, off};
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed((AngleW+1)'(AngleMax))) begin
      clamped = PhaseW'(AngleMax);
    end else begin
      clamped = sum[PhaseW-1:0];
    end
    prod = {{RecipW{1'b0}}, clamped} * (PhaseW+RecipW)'(DutyRecip);
    return DutyW'(DutyMin) + prod[DutyShift+DutyW-1:DutyShift];
  endfunction

endpackage

// File: hdl/quad_servo_gait_pose_controller.sv
// Path: an accepted input transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while out_stall_i is low; the single-pass update of state and duties sets that.
// Reset (rst_ni low, async): joints 90, offsets 0, walk stopped, phase 0 rising, pipeline empty.
// Quadruped servo gait and pose controller, top level.
// Depends on qsgpc_pkg.
module quad_servo_gait_pose_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [qsgpc_pkg::OffsetW-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic                                  safety_locked_i,
  input  logic [2:0]                            joint_group_i,
  input  logic signed [qsgpc_pkg::AngleW-1:0]   joint_angle_i,
  input  logic [2:0]                            pose_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [qsgpc_pkg::DutyW-1:0]           duty_back_left_o,
  output logic [qsgpc_pkg::DutyW-1:0]           duty_front_right_o,
  output logic [qsgpc_pkg::DutyW-1:0]           duty_front_left_o,
  output logic [qsgpc_pkg::DutyW-1:0]           duty_back_right_o,
  output logic signed [qsgpc_pkg::AngleW-1:0]   angle_back_left_o,
  output logic signed [qsgpc_pkg::AngleW-1:0]   angle_front_right_o,
  output logic signed [qsgpc_pkg::AngleW-1:0]   angle_front_left_o,
  output logic signed [qsgpc_pkg::AngleW-1:0]   angle_back_right_o,
  output logic [1:0]                            walk_mode_o,
  output logic                                  duty_updated_o
);

  localparam int unsigned NJ = qsgpc_pkg::NumJoints;

  // input register
  logic                      in_valid_q;
  qsgpc_pkg::action_e        act_q;
  logic                      lock_q;
  qsgpc_pkg::group_e         grp_q;
  qsgpc_pkg::angle_t         ang_q;
  qsgpc_pkg::pose_e          pose_q;

  // state
  qsgpc_pkg::angle_t         joint_q [NJ];
  qsgpc_pkg::angle_t         joint_d [NJ];
  qsgpc_pkg::offset_t        off_q   [NJ];
  qsgpc_pkg::gait_e          gait_q, gait_d;
  qsgpc_pkg::phase_t         pos_q, pos_d;
  logic                      rise_q, rise_d;

  // result register
  logic                      out_valid_q;
  qsgpc_pkg::duty_t          duty_q [NJ];
  qsgpc_pkg::duty_t          duty_d [NJ];
  logic                      upd_q, upd_d;

  logic                      out_ready, in_ready, adv;
  logic signed [qsgpc_pkg::PhaseW:0] pos_step;
  qsgpc_pkg::angle_t         ph_a, ph_b;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      act_q  <= qsgpc_pkg::action_e'(action_i);
      lock_q <= safety_locked_i;
      grp_q  <= qsgpc_pkg::group_e'(joint_group_i);
      ang_q  <= joint_angle_i;
      pose_q <= qsgpc_pkg::pose_e'(pose_i);
    end
  end

  always_comb begin
    pos_step = rise_q ? $signed({1'b0, pos_q}) + $signed(9'(qsgpc_pkg::PhaseStep))
                      : $signed({1'b0, pos_q}) - $signed(9'(qsgpc_pkg::PhaseStep));
    if (pos_step >= $signed(9'(qsgpc_pkg::AngleMax))) begin
      pos_d  = qsgpc_pkg::PhaseW'(qsgpc_pkg::AngleMax);
      rise_d = 1'b0;
    end else if (pos_step <= 0) begin
      pos_d  = '0;
      rise_d = 1'b1;
    end else begin
      pos_d  = pos_step[qsgpc_pkg::PhaseW-1:0];
      rise_d = rise_q;
    end
    ph_a = qsgpc_pkg::AngleW'(pos_d);
    ph_b = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMax) - ph_a;
  end

  always_comb begin
    qsgpc_pkg::angle_t fr, bk;
    logic              set_fb;
    fr      = ang_q;
    bk      = ang_q;
    set_fb  = 1'b0;
    joint_d = joint_q;
    gait_d  = gait_q;
    upd_d   = 1'b0;
    case (act_q)
      qsgpc_pkg::ACT_TICK: begin
        if (lock_q) begin
          fr     = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
          bk     = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
          set_fb = 1'b1;
          gait_d = qsgpc_pkg::GAIT_NONE;
          upd_d  = 1'b1;
        end else if (gait_q == qsgpc_pkg::GAIT_FWD) begin
          fr     = ph_a;
          bk     = ph_b;
          set_fb = 1'b1;
          upd_d  = 1'b1;
        end else if (gait_q == qsgpc_pkg::GAIT_BWD) begin
          fr     = ph_b;
          bk     = ph_a;
          set_fb = 1'b1;
          upd_d  = 1'b1;
        end
      end
      qsgpc_pkg::ACT_TARGET: begin
        if (!lock_q) begin
          gait_d = qsgpc_pkg::GAIT_NONE;
          upd_d  = 1'b1;
          case (grp_q)
            qsgpc_pkg::GRP_BACK_LEFT:   joint_d[qsgpc_pkg::JBackLeft]   = ang_q;
            qsgpc_pkg::GRP_FRONT_RIGHT: joint_d[qsgpc_pkg::JFrontRight] = ang_q;
            qsgpc_pkg::GRP_FRONT_LEFT:  joint_d[qsgpc_pkg::JFrontLeft]  = ang_q;
            qsgpc_pkg::GRP_BACK_RIGHT:  joint_d[qsgpc_pkg::JBackRight]  = ang_q;
            qsgpc_pkg::GRP_ALL:         set_fb = 1'b1;
            qsgpc_pkg::GRP_FRONT: begin
              joint_d[qsgpc_pkg::JFrontLeft]  = ang_q;
              joint_d[qsgpc_pkg::JFrontRight] = ang_q;
            end
            qsgpc_pkg::GRP_BACK: begin
              joint_d[qsgpc_pkg::JBackLeft]  = ang_q;
              joint_d[qsgpc_pkg::JBackRight] = ang_q;
            end
            default: ;
          endcase
        end
      end
      qsgpc_pkg::ACT_POSE: begin
        if (!lock_q) begin
          gait_d = qsgpc_pkg::GAIT_NONE;
          upd_d  = 1'b1;
          case (pose_q)
            qsgpc_pkg::POSE_FORWARD: begin
              gait_d = qsgpc_pkg::GAIT_FWD;
              upd_d  = 1'b0;
            end
            qsgpc_pkg::POSE_BACKWARD: begin
              gait_d = qsgpc_pkg::GAIT_BWD;
              upd_d  = 1'b0;
            end
            qsgpc_pkg::POSE_SIT: begin
              fr = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMax);
              bk = '0;
              set_fb = 1'b1;
            end
            qsgpc_pkg::POSE_STAND: begin
              fr = '0;
              bk = '0;
              set_fb = 1'b1;
            end
            qsgpc_pkg::POSE_STRETCH_DOWN: begin
              fr = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMax);
              bk = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
              set_fb = 1'b1;
            end
            qsgpc_pkg::POSE_STRETCH_BACK: begin
              fr = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
              bk = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMax);
              set_fb = 1'b1;
            end
            qsgpc_pkg::POSE_STOP: begin
              fr = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
              bk = qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
              set_fb = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (set_fb) begin
      joint_d[qsgpc_pkg::JFrontLeft]  = fr;
      joint_d[qsgpc_pkg::JFrontRight] = fr;
      joint_d[qsgpc_pkg::JBackLeft]   = bk;
      joint_d[qsgpc_pkg::JBackRight]  = bk;
    end
    for (int i = 0; i < NJ; i++) begin
      duty_d[i] = qsgpc_pkg::duty_of(joint_d[i], off_q[i]);
    end
  end

  // phase only moves on a gait tick
  logic phase_en;
  assign phase_en = adv && (act_q == qsgpc_pkg::ACT_TICK) && !lock_q &&
                    (gait_q != qsgpc_pkg::GAIT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NJ; i++) begin
        joint_q[i] <= qsgpc_pkg::AngleW'(qsgpc_pkg::AngleMid);
      end
      gait_q <= qsgpc_pkg::GAIT_NONE;
      pos_q  <= '0;
      rise_q <= 1'b1;
    end else begin
      if (adv) begin
        joint_q <= joint_d;
        gait_q  <= gait_d;
      end
      if (phase_en) begin
        pos_q  <= pos_d;
        rise_q <= rise_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NJ; i++) begin
        off_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      off_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      duty_q <= duty_d;
      upd_q  <= upd_d;
    end
  end

  // angles and walk mode are the state after the transaction held in the result register
  assign out_valid_o         = out_valid_q;
  assign duty_back_left_o    = duty_q[qsgpc_pkg::JBackLeft];
  assign duty_front_right_o  = duty_q[qsgpc_pkg::JFrontRight];
  assign duty_front_left_o   = duty_q[qsgpc_pkg::JFrontLeft];
  assign duty_back_right_o   = duty_q[qsgpc_pkg::JBackRight];
  assign angle_back_left_o   = joint_q[qsgpc_pkg::JBackLeft];
  assign angle_front_right_o = joint_q[qsgpc_pkg::JFrontRight];
  assign angle_front_left_o  = joint_q[qsgpc_pkg::JFrontLeft];
  assign angle_back_right_o  = joint_q[qsgpc_pkg::JBackRight];
  assign walk_mode_o         = gait_q;
  assign duty_updated_o      = upd_q;

  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output side is free");

  a_res_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a registered transaction");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= qsgpc_pkg::PhaseW'(qsgpc_pkg::AngleMax))
    else $error("phase out of range");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_back_left_o >= qsgpc_pkg::DutyW'(qsgpc_pkg::DutyMin)) &&
                    (duty_front_right_o <= qsgpc_pkg::DutyW'(qsgpc_pkg::DutyMax)))
    else $error("duty out of range");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(gait_q) && $stable(pos_q))
    else $error("state moved while result held");

endmodule
